// ----- rtl/core/bmrsc_pkg.sv -----
`timescale 1ns / 1ps

package bmrsc_pkg;

	// Field widths fixed by the stream format
	localparam int COORD_W     = 10;
	localparam int CMD_W       = 2;
	localparam int CNT_W       = 21;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

	// Defaults for the top-level parameters
	localparam int GRID_DIM_DEF  = 1024;
	localparam int WORD_BITS_DEF = 64;

	// Entries in the queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;

	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [CMD_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_SET    = 2'd1,
		OP_INVERT = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// One classified rectangle job, ready for the back end
	typedef struct packed {
		op_t    op;
		coord_t x_first;
		coord_t x_last;
		coord_t y_first;
		coord_t y_last;
		coord_t w_first;     // first word index in a row
		coord_t w_last;      // last word index in a row
		coord_t base_first;  // column of bit 0 of the first word
	} entry_t;

endpackage

// ----- rtl/core/bmrsc_ram.sv -----
`timescale 1ns / 1ps

module bmrsc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/bmrsc_fifo.sv -----
`timescale 1ns / 1ps

module bmrsc_fifo
	import bmrsc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t pop_data,
	output logic   valid
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	entry_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    count_q;

	assign full     = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	// Hold queued entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/core/bmrsc_front.sv -----
`timescale 1ns / 1ps

module bmrsc_front
	import bmrsc_pkg::*;
#(
	parameter int GRID_DIM  = GRID_DIM_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic                  clr_done,
	input  logic                  q_full,
	output logic                  q_push,
	output entry_t                q_data
);

	// Largest coordinate that the grid holds, as seen through a 10-bit field
	localparam int COORD_MAX_I = (GRID_DIM - 1 > (1 << COORD_W) - 1) ?
	                             (1 << COORD_W) - 1 : GRID_DIM - 1;
	localparam coord_t COORD_MAX = coord_t'(COORD_MAX_I);

	// Reciprocal for column / WORD_BITS; estimate is low by at most one
	localparam int RECIP_SH = COORD_W + 1;
	localparam int RECIP    = (1 << RECIP_SH) / WORD_BITS;
	localparam int RECIP_W  = $clog2(RECIP + 1);
	localparam int PROD_W   = COORD_W + RECIP_W;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_FIX
	} fstate_t;

	fstate_t state_q;
	entry_t  ent_q;
	coord_t  q_first_q;
	coord_t  q_last_q;

	op_t    cmd_op;
	coord_t x0, y0, x1s, y1s;
	logic   accept;

	logic [PROD_W-1:0] prod_first, prod_last;
	coord_t qm_first, qm_last, r_first, r_last;

	assign s_tready = (state_q == F_IDLE) && clr_done;
	assign accept   = s_tvalid && s_tready;

	// Unpack fields and saturate the last corner
	always_comb begin
		cmd_op = op_t'(s_tdata[CMD_W-1:0]);
		x0     = s_tdata[CMD_W +: COORD_W];
		y0     = s_tdata[CMD_W + COORD_W +: COORD_W];
		x1s    = s_tdata[CMD_W + 2*COORD_W +: COORD_W];
		y1s    = s_tdata[CMD_W + 3*COORD_W +: COORD_W];
		if (x1s > COORD_MAX) begin
			x1s = COORD_MAX;
		end
		if (y1s > COORD_MAX) begin
			y1s = COORD_MAX;
		end
	end

	// Estimate word indices of both x corners
	assign prod_first = PROD_W'(ent_q.x_first) * PROD_W'(RECIP);
	assign prod_last  = PROD_W'(ent_q.x_last) * PROD_W'(RECIP);

	// Correct the estimates and build the queue entry
	always_comb begin
		qm_first = q_first_q * coord_t'(WORD_BITS);
		qm_last  = q_last_q * coord_t'(WORD_BITS);
		r_first  = ent_q.x_first - qm_first;
		r_last   = ent_q.x_last - qm_last;
		q_data   = ent_q;
		if (r_first >= coord_t'(WORD_BITS)) begin
			q_data.w_first    = q_first_q + coord_t'(1);
			q_data.base_first = qm_first + coord_t'(WORD_BITS);
		end else begin
			q_data.w_first    = q_first_q;
			q_data.base_first = qm_first;
		end
		if (r_last >= coord_t'(WORD_BITS)) begin
			q_data.w_last = q_last_q + coord_t'(1);
		end else begin
			q_data.w_last = q_last_q;
		end
	end

	assign q_push = (state_q == F_FIX) && !q_full;

	// Sequence one item: accept, estimate, correct and push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					state_q <= F_FIX;
				end
				F_FIX: begin
					if (q_push) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Hold the classified fields and the quotient estimates
	always_ff @(posedge clk) begin
		if (accept) begin
			if (cmd_op == OP_NONE || x0 > x1s || y0 > y1s) begin
				ent_q.op <= OP_NONE;
			end else begin
				ent_q.op <= cmd_op;
			end
			ent_q.x_first    <= x0;
			ent_q.x_last     <= x1s;
			ent_q.y_first    <= y0;
			ent_q.y_last     <= y1s;
			ent_q.w_first    <= '0;
			ent_q.w_last     <= '0;
			ent_q.base_first <= '0;
		end
		if (state_q == F_DIV) begin
			q_first_q <= coord_t'(prod_first >> RECIP_SH);
			q_last_q  <= coord_t'(prod_last >> RECIP_SH);
		end
	end

endmodule

// ----- rtl/core/bmrsc_back.sv -----
`timescale 1ns / 1ps

module bmrsc_back
	import bmrsc_pkg::*;
#(
	parameter int GRID_DIM  = GRID_DIM_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  entry_t                 q_data,
	output logic                   q_pop,
	output logic                   clr_done,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int ROW_WORDS = (GRID_DIM + WORD_BITS - 1) / WORD_BITS;
	localparam int MAP_WORDS = ROW_WORDS * GRID_DIM;
	localparam int AW        = $clog2(MAP_WORDS);
	localparam int BYTES     = (WORD_BITS + 7) / 8;
	localparam int PW        = BYTES * 8;
	localparam int SUM_W     = $clog2(PW + 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_DRAIN
	} bstate_t;

	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

	bstate_t          state_q;
	logic [AW-1:0]    clr_addr_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] lit_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] total_d;

	// Rectangle walk
	entry_t        ent_q;
	coord_t        y_q;
	coord_t        w_q;
	coord_t        col_q;
	logic [AW-1:0] row_base_q;

	// Issue signals
	logic                 issue_v;
	logic                 issue_last;
	logic                 issue_rd;
	logic [WORD_BITS-1:0] issue_mask;
	logic [AW-1:0]        issue_addr;
	logic                 run_last;

	// Pipeline registers
	logic                 valid_s1, last_s1;
	op_t                  op_s1;
	logic [WORD_BITS-1:0] mask_s1;
	logic [AW-1:0]        addr_s1;
	logic                 valid_s2, last_s2;
	logic [PW-1:0]        gain_s2, loss_s2;
	logic                 valid_s3, last_s3;
	logic [3:0]           gcnt_s3 [BYTES];
	logic [3:0]           lcnt_s3 [BYTES];

	// Memory ports
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] new_word;

	logic [SUM_W-1:0] gsum, lsum;

	assign clr_done = (state_q != ST_CLEAR);
	assign q_pop    = (state_q == ST_IDLE) && q_valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(lit_q);
	assign run_last = (w_q == ent_q.w_last) && (y_q == ent_q.y_last);

	// Column mask of the word under the walk
	always_comb begin
		logic [COORD_W:0] col;
		for (int b = 0; b < WORD_BITS; b++) begin
			col = {1'b0, col_q} + (COORD_W+1)'(b);
			issue_mask[b] = (col >= {1'b0, ent_q.x_first}) && (col <= {1'b0, ent_q.x_last});
		end
	end

	// Issue one word per cycle, or a single empty token for an idle command
	always_comb begin
		issue_addr = row_base_q + AW'(w_q);
		issue_rd   = (state_q == ST_RUN);
		issue_v    = issue_rd || ((state_q == ST_SETUP) && (ent_q.op == OP_NONE));
		issue_last = (state_q == ST_SETUP) ? 1'b1 : run_last;
	end

	bmrsc_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue_rd),
		.raddr (issue_addr),
		.rdata (rd_word)
	);

	// Apply the operation to the word read back
	always_comb begin
		unique case (op_s1)
			OP_CLEAR:  new_word = rd_word & ~mask_s1;
			OP_SET:    new_word = rd_word | mask_s1;
			OP_INVERT: new_word = rd_word ^ mask_s1;
			OP_NONE:   new_word = rd_word;
			default:   new_word = rd_word;
		endcase
	end

	// Write port: clearing sweep after reset, else the modified word
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = valid_s1 && (op_s1 != OP_NONE);
			ram_waddr = addr_s1;
			ram_wdata = new_word;
		end
	end

	// Sum byte counts into the running total
	always_comb begin
		gsum = '0;
		lsum = '0;
		for (int i = 0; i < BYTES; i++) begin
			gsum = gsum + SUM_W'(gcnt_s3[i]);
			lsum = lsum + SUM_W'(lcnt_s3[i]);
		end
		total_d = total_q + CNT_W'(gsum) - CNT_W'(lsum);
	end

	// Pipeline control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			valid_s3 <= 1'b0;
			last_s3  <= 1'b0;
		end else begin
			valid_s1 <= issue_v;
			last_s1  <= issue_v && issue_last;
			valid_s2 <= valid_s1;
			last_s2  <= valid_s1 && last_s1;
			valid_s3 <= valid_s2;
			last_s3  <= valid_s2 && last_s2;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		op_s1   <= (state_q == ST_RUN) ? ent_q.op : OP_NONE;
		mask_s1 <= (state_q == ST_RUN) ? issue_mask : '0;
		addr_s1 <= issue_addr;
		if (op_s1 == OP_NONE) begin
			gain_s2 <= '0;
			loss_s2 <= '0;
		end else begin
			gain_s2 <= PW'(new_word & ~rd_word);
			loss_s2 <= PW'(rd_word & ~new_word);
		end
		for (int i = 0; i < BYTES; i++) begin
			gcnt_s3[i] <= pop8(gain_s2[8*i +: 8]);
			lcnt_s3[i] <= pop8(loss_s2[8*i +: 8]);
		end
	end

	// Keep the running count of set cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (valid_s3) begin
			total_q <= total_d;
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			lit_q       <= '0;
		end else begin
			if (valid_s3 && last_s3) begin
				out_valid_q <= 1'b1;
				lit_q       <= total_d;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(MAP_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= (ent_q.op == OP_NONE) ? ST_DRAIN : ST_RUN;
				end
				ST_RUN: begin
					if (run_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (valid_s3 && last_s3) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk rows and words of the rectangle
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_data;
		end
		if (state_q == ST_SETUP) begin
			y_q        <= ent_q.y_first;
			w_q        <= ent_q.w_first;
			col_q      <= ent_q.base_first;
			row_base_q <= AW'(ent_q.y_first) * AW'(ROW_WORDS);
		end else if (state_q == ST_RUN) begin
			if (w_q == ent_q.w_last) begin
				y_q        <= y_q + coord_t'(1);
				row_base_q <= row_base_q + AW'(ROW_WORDS);
				w_q        <= ent_q.w_first;
				col_q      <= ent_q.base_first;
			end else begin
				w_q   <= w_q + coord_t'(1);
				col_q <= col_q + coord_t'(WORD_BITS);
			end
		end
	end

	// No word is in flight while the bitmap is being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !valid_s1)
		else $error("bitmap access during clearing sweep");

	// A finished item always finds the result register empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && last_s3) |-> !out_valid_q)
		else $error("result register overwritten");

	// The walk stays inside the rectangle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (w_q <= ent_q.w_last && y_q <= ent_q.y_last))
		else $error("rectangle walk out of bounds");

	// One item at a time: nothing is pending when the next job is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!valid_s1 && !valid_s2 && !valid_s3))
		else $error("new job started with words in flight");

endmodule

// ----- rtl/core/bitmap_rect_set_clear_toggle.sv -----
`timescale 1ns / 1ps

// Rectangle set / clear / invert on a GRID_DIM x GRID_DIM one-bit bitmap that
// keeps a running count of set cells and returns it once per command. After
// reset the bitmap memory, ceil(GRID_DIM / WORD_BITS) * GRID_DIM words (16384
// at the defaults), is swept to zero, one word a cycle; s_tready stays low
// during that sweep. The front end takes one command at a time, estimates and
// corrects its word indices and queues it, stalling while the queue is full;
// the back end then reads, modifies and writes back one bitmap word per cycle,
// over (rows in the rectangle) x (words spanned per row) words, besides taking
// the job, setting up and draining the pipeline, and it takes a new job only
// while the result register is free or being emptied. An empty, reversed or
// unused command touches no word but still returns the count. The back end's
// rate is set by the single-word read-modify-write of the bitmap memory.
module bitmap_rect_set_clear_toggle
	import bmrsc_pkg::*;
#(
	parameter int GRID_DIM  = GRID_DIM_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// cmd[1:0], x_first[11:2], y_first[21:12], x_last[31:22], y_last[41:32]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// lit_count[20:0]
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	entry_t push_data, pop_data;
	logic   push, pop, q_full, q_valid, clr_done;

	bmrsc_front #(
		.GRID_DIM  (GRID_DIM),
		.WORD_BITS (WORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.clr_done (clr_done),
		.q_full   (q_full),
		.q_push   (push),
		.q_data   (push_data)
	);

	bmrsc_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.valid     (q_valid)
	);

	bmrsc_back #(
		.GRID_DIM  (GRID_DIM),
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (pop_data),
		.q_pop    (pop),
		.clr_done (clr_done),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import bmrsc_pkg::*;

	localparam int MAP_DIM     = GRID_DIM_DEF;
	localparam int MAP_WORD    = WORD_BITS_DEF;
	localparam int ROW_WORDS   = (MAP_DIM + MAP_WORD - 1) / MAP_WORD;
	localparam int MAP_WORDS   = ROW_WORDS * MAP_DIM;
	localparam int COORD_MAX   = MAP_DIM - 1;
	localparam int PHASE_ITEMS = 26;
	localparam int HOLD_AT     = 78;
	localparam int HOLD_LEN    = 500;
	localparam int STALL_LIMIT = 100000;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		op_t    op;
		coord_t x_first;
		coord_t y_first;
		coord_t x_last;
		coord_t y_last;
	} rect_cmd_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Rectangles waiting to be offered, and counts waiting to come back
	rect_cmd_t        rect_backlog[$];
	logic [CNT_W-1:0] lit_count_due[$];
	rect_cmd_t        offered_rect;
	logic [CNT_W-1:0] want_count;

	// Shadow copy of the bitmap and its set-cell total
	bit [MAP_WORD-1:0] shadow_map [MAP_WORDS];
	int unsigned       shadow_total = 0;

	int unsigned send_idle_pct = 26;
	int unsigned recv_idle_pct = 62;
	int unsigned hold_left     = 0;
	int unsigned items_sent    = 0;
	int unsigned results_seen  = 0;
	int unsigned mismatch_count = 0;
	int unsigned grid_cmds     = 0;
	int unsigned void_cmds     = 0;

	bitmap_rect_set_clear_toggle dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic logic [IN_TDATA_W-1:0] pack_rect(rect_cmd_t r);
		return {{(IN_TDATA_W - CMD_W - 4 * COORD_W){1'b0}},
			r.y_last, r.x_last, r.y_first, r.x_first, r.op};
	endfunction

	// Apply one rectangle to the shadow bitmap word by word; return the new count
	function automatic logic [CNT_W-1:0] apply_to_shadow(rect_cmd_t r);
		int unsigned x0, y0, x1, y1, row, w, base, lo, hi, idx;
		bit [MAP_WORD-1:0] mask, old_w, new_w;
		x0 = r.x_first;
		y0 = r.y_first;
		x1 = (r.x_last > COORD_MAX) ? COORD_MAX : r.x_last;
		y1 = (r.y_last > COORD_MAX) ? COORD_MAX : r.y_last;
		if (r.op != OP_NONE && x0 <= x1 && y0 <= y1) begin
			for (row = y0; row <= y1; row++) begin
				for (w = x0 / MAP_WORD; w <= x1 / MAP_WORD; w++) begin
					base  = w * MAP_WORD;
					lo    = (x0 > base) ? x0 - base : 0;
					hi    = (x1 < base + MAP_WORD - 1) ? x1 - base : MAP_WORD - 1;
					mask  = ({MAP_WORD{1'b1}} >> (MAP_WORD - 1 - hi)) & ({MAP_WORD{1'b1}} << lo);
					idx   = row * ROW_WORDS + w;
					old_w = shadow_map[idx];
					case (r.op)
						OP_CLEAR: new_w = old_w & ~mask;
						OP_SET:   new_w = old_w | mask;
						default:  new_w = old_w ^ mask;
					endcase
					shadow_total = shadow_total - $countones(old_w & mask)
						+ $countones(new_w & mask);
					shadow_map[idx] = new_w;
				end
			end
		end
		return shadow_total[CNT_W-1:0];
	endfunction

	task automatic push_rect(op_t op, int unsigned x0, int unsigned y0,
		int unsigned x1, int unsigned y1);
		rect_cmd_t r;
		r.op      = op;
		r.x_first = coord_t'(x0);
		r.y_first = coord_t'(y0);
		r.x_last  = coord_t'(x1);
		r.y_last  = coord_t'(y1);
		if (op == OP_NONE || x0 > x1 || y0 > y1)
			void_cmds++;
		else if ((y1 - y0) * ((x1 / MAP_WORD) - (x0 / MAP_WORD) + 1) > 4096)
			grid_cmds++;
		rect_backlog.push_back(r);
	endtask

	// Mostly small well-formed rectangles, a few grid-sized ones, some no-ops
	task automatic push_random_rect();
		int unsigned kind, x0, y0, x1, y1;
		op_t op;
		kind = $urandom_range(99);
		op   = op_t'($urandom_range(2));
		if (kind < 3) begin
			x0 = $urandom_range(3);
			y0 = $urandom_range(3);
			push_rect(op, x0, y0, COORD_MAX - $urandom_range(3), COORD_MAX - $urandom_range(3));
		end else if (kind < 82) begin
			if ($urandom_range(1)) begin
				x0 = $urandom_range(255);
				y0 = $urandom_range(255);
			end else begin
				x0 = $urandom_range(COORD_MAX);
				y0 = $urandom_range(COORD_MAX);
			end
			x1 = x0 + $urandom_range(150);
			y1 = y0 + $urandom_range(20);
			if (x1 > COORD_MAX) x1 = COORD_MAX;
			if (y1 > COORD_MAX) y1 = COORD_MAX;
			push_rect(op, x0, y0, x1, y1);
		end else if (kind < 91) begin
			x1 = $urandom_range(COORD_MAX - 1);
			y1 = $urandom_range(COORD_MAX - 1);
			if ($urandom_range(1))
				push_rect(op, $urandom_range(COORD_MAX, x1 + 1), $urandom_range(y1), x1, y1);
			else
				push_rect(op, $urandom_range(x1), $urandom_range(COORD_MAX, y1 + 1), x1, y1);
		end else begin
			push_rect($urandom_range(1) ? OP_NONE : op, $urandom_range(COORD_MAX),
				$urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
				$urandom_range(COORD_MAX));
		end
	endtask

	// Hold the feed until everything offered has been answered
	task automatic wait_drained();
		while (rect_backlog.size() != 0 || s_tvalid) @(posedge clk);
		while (lit_count_due.size() != 0) @(posedge clk);
	endtask

	// Offer rectangles; predict the count on each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				lit_count_due.push_back(apply_to_shadow(offered_rect));
				items_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (rect_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered_rect = rect_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= pack_rect(offered_rect);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Check each returned count; throttle the result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (lit_count_due.size() == 0) begin
					report_mismatch($sformatf("count %0d arrived with none pending",
						m_tdata[CNT_W-1:0]));
				end else begin
					want_count = lit_count_due.pop_front();
					if (m_tdata[CNT_W-1:0] !== want_count)
						report_mismatch($sformatf("lit_count %0d, expected %0d",
							m_tdata[CNT_W-1:0], want_count));
				end
				results_seen++;
				if (results_seen == HOLD_AT)
					hold_left = HOLD_LEN;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Abort when no transfer happens on either side for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("bitmap_rect_set_clear_toggle verification failed");
		$finish;
	end

	initial begin : sequencer
		int phase;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: grid extremes, word edges, every op, no-op cases
		push_rect(OP_SET,    0, 0, COORD_MAX, COORD_MAX);
		push_rect(OP_INVERT, 0, 0, COORD_MAX, COORD_MAX);
		push_rect(OP_SET,    0, 0, 0, 0);
		push_rect(OP_SET,    COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		push_rect(OP_INVERT, 60, 5, 70, 9);
		push_rect(OP_CLEAR,  63, 0, 64, COORD_MAX);
		push_rect(OP_SET,    10, 0, 5, 5);
		push_rect(OP_SET,    0, 10, 5, 5);
		push_rect(OP_NONE,   0, 0, COORD_MAX, COORD_MAX);
		push_rect(OP_SET,    0, 512, COORD_MAX, 512);
		push_rect(OP_INVERT, 1, 1, COORD_MAX - 1, COORD_MAX - 1);
		push_rect(OP_CLEAR,  0, 0, COORD_MAX, 0);
		push_rect(OP_SET,    960, 1000, COORD_MAX, COORD_MAX);
		push_rect(OP_SET,    10'h155, 10'h2AA, 10'h2AA, 10'h355);
		push_rect(OP_INVERT, 10'h2AA, 10'h155, 10'h355, 10'h2AA);
		push_rect(OP_CLEAR,  0, 0, COORD_MAX, COORD_MAX);
		push_rect(OP_SET,    127, 127, 128, 128);
		push_rect(OP_INVERT, 127, 127, 128, 128);
		push_rect(OP_SET,    500, 0, 500, COORD_MAX);
		push_rect(OP_CLEAR,  500, 300, 500, 300);
		push_rect(OP_INVERT, COORD_MAX, 0, COORD_MAX, 0);
		push_rect(OP_NONE,   3, 3, 9, 9);
		wait_drained();

		// Random phases: sender-light, receiver-light, then no idling
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 62 : 0;
			recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 26 : 0;
			repeat (PHASE_ITEMS) push_random_rect();
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d rectangle commands (%0d grid-sized, %0d with no effect)",
			items_sent, grid_cmds, void_cmds);
		$display("Checked %0d returned counts under three throttling mixes and a long hold",
			results_seen);
		if (mismatch_count == 0) begin
			$display("bitmap_rect_set_clear_toggle verification clean");
		end else begin
			$display("bitmap_rect_set_clear_toggle verification failed");
		end
		$finish;
	end

endmodule

// ----- bitmap_rect_set_clear_toggle.f -----
rtl/core/bmrsc_pkg.sv
rtl/core/bmrsc_ram.sv
rtl/core/bmrsc_fifo.sv
rtl/core/bmrsc_front.sv
rtl/core/bmrsc_back.sv
rtl/core/bitmap_rect_set_clear_toggle.sv
tb/sv/tb.sv
